// File: rtl/lkv_pkg.sv
// Shared constants, types and key helpers for the LRU key-value cache.
package lkv_pkg;

   // Store geometry
   localparam int ENTRIES   = 16;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int RANK_W    = IDX_W;
   localparam int TAG_W     = KEY_WIDTH + RANK_W;

   // Field widths
   localparam int DATA_W  = 32;
   localparam int EXT_W   = 64;
   localparam int LIMIT_W = 5;
   localparam int CMP_W   = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

   // Limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_LIMIT = CSR_IDX_W'(0);

   // Read data returned by a get that misses
   localparam logic [DATA_W-1:0] READ_MISS = '1;

   typedef enum logic {
      FUNC_GET = 1'b0,
      FUNC_PUT = 1'b1
   } func_type;

   // Result beat, hit in the lowest bit
   typedef struct packed {
      logic [DATA_W-1:0] evicted_key;
      logic              evicted;
      logic [DATA_W-1:0] read_data;
      logic              hit;
   } result_type;

   localparam int RESULT_W    = $bits(result_type);
   localparam int RSP_TDATA_W = ((RESULT_W + 7) / 8) * 8;
   localparam int REQ_TDATA_W = 2 * DATA_W;

   // Sign-extend a request key, then cut it to the stored key width
   function automatic logic [KEY_WIDTH-1:0] key_from_req(input logic [DATA_W-1:0] raw);
      logic [EXT_W-1:0] ext;
      ext = {{(EXT_W - DATA_W){raw[DATA_W-1]}}, raw};
      return ext[KEY_WIDTH-1:0];
   endfunction

   // Low data-width bits of a stored key, zero-extended when the key is narrower
   function automatic logic [DATA_W-1:0] key_low(input logic [KEY_WIDTH-1:0] key);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(key);
      return ext[DATA_W-1:0];
   endfunction

endpackage

// File: rtl/lkv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lkv_csr.sv
// Register port holding the entry limit.
module lkv_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [lkv_pkg::LIMIT_W-1:0]       entry_limit
);

   logic [lkv_pkg::LIMIT_W-1:0]   limit_ff;
   logic [lkv_pkg::CSR_IDX_W-1:0] reg_idx;
   logic                          wr_access;

   assign reg_idx    = csr_paddr[lkv_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_access  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Take the limit on the access phase of a write
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lkv_pkg::LIMIT_RESET;
      end else if (wr_access && (reg_idx == lkv_pkg::REG_ENTRY_LIMIT)) begin
         limit_ff <= csr_pwdata[lkv_pkg::LIMIT_W-1:0];
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         lkv_pkg::REG_ENTRY_LIMIT: csr_prdata = lkv_pkg::CSR_DATA_W'(limit_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign entry_limit = limit_ff;

endmodule

// File: rtl/lkv_engine.sv
// Lookup engine: scans the tag memory, decides hit, insert or eviction, then re-ranks.
module lkv_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lkv_pkg::LIMIT_W-1:0]   entry_limit,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [lkv_pkg::DATA_W-1:0]    req_key,
   input  logic [lkv_pkg::DATA_W-1:0]    req_value,
   output logic                          res_valid,
   input  logic                          res_ready,
   output lkv_pkg::result_type           res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP,
      ST_RESP
   } state_type;

   state_type                      state_ff;
   logic [lkv_pkg::CNT_W-1:0]      cnt_ff;

   // Request held for the whole operation
   lkv_pkg::func_type              func_ff;
   logic [lkv_pkg::KEY_WIDTH-1:0]  key_ff;
   logic [lkv_pkg::DATA_W-1:0]     value_ff;

   // Occupancy
   logic [lkv_pkg::ENTRIES-1:0]    valid_ff;
   logic [lkv_pkg::CNT_W-1:0]      count_ff;

   // Scan trackers
   logic                           found_ff;
   logic [lkv_pkg::IDX_W-1:0]      found_idx_ff;
   logic [lkv_pkg::RANK_W-1:0]     found_rank_ff;
   logic                           lru_ff;
   logic [lkv_pkg::IDX_W-1:0]      lru_idx_ff;
   logic [lkv_pkg::RANK_W-1:0]     lru_rank_ff;
   logic [lkv_pkg::KEY_WIDTH-1:0]  lru_key_ff;
   logic                           free_ff;
   logic [lkv_pkg::IDX_W-1:0]      free_idx_ff;

   // Re-rank sweep controls
   logic [lkv_pkg::IDX_W-1:0]      target_idx_ff;
   logic [lkv_pkg::CNT_W-1:0]      thr_ff;
   logic                           ins_ff;
   logic                           load_value_ff;

   lkv_pkg::result_type            res_ff;

   // Memory ports
   logic                           tag_wr_en;
   logic [lkv_pkg::TAG_W-1:0]      tag_wr_data;
   logic                           tag_rd_en;
   logic [lkv_pkg::TAG_W-1:0]      tag_rd_data;
   logic                           val_wr_en;
   logic [lkv_pkg::IDX_W-1:0]      val_wr_addr;
   logic                           val_rd_en;
   logic [lkv_pkg::DATA_W-1:0]     val_rd_data;

   // Row under processing (read in the previous cycle)
   logic [lkv_pkg::CNT_W-1:0]      row_cnt;
   logic [lkv_pkg::IDX_W-1:0]      row_idx;
   logic                           row_live;
   logic                           row_valid;
   logic [lkv_pkg::KEY_WIDTH-1:0]  row_key;
   logic [lkv_pkg::RANK_W-1:0]     row_rank;
   logic                           issue_live;

   // Decision terms
   logic                           is_put;
   logic [lkv_pkg::CMP_W-1:0]      lim_eff;
   logic                           need_evict;
   logic                           self_evict;
   logic [lkv_pkg::IDX_W-1:0]      free_sel;
   logic                           sweep_go;

   assign row_cnt    = cnt_ff - lkv_pkg::CNT_W'(1);
   assign row_idx    = row_cnt[lkv_pkg::IDX_W-1:0];
   assign row_live   = (cnt_ff != '0);
   assign issue_live = (cnt_ff < lkv_pkg::CNT_W'(lkv_pkg::ENTRIES));
   assign row_valid  = valid_ff[row_idx];
   assign row_key    = tag_rd_data[lkv_pkg::TAG_W-1:lkv_pkg::RANK_W];
   assign row_rank   = tag_rd_data[lkv_pkg::RANK_W-1:0];

   // Effective limit and the eviction decision for a new key
   always_comb begin
      is_put = (func_ff == lkv_pkg::FUNC_PUT);
      if (lkv_pkg::CMP_W'(entry_limit) > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
         lim_eff = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
      end else begin
         lim_eff = lkv_pkg::CMP_W'(entry_limit);
      end
      need_evict = (lkv_pkg::CMP_W'(count_ff) + lkv_pkg::CMP_W'(1)) > lim_eff;
      self_evict = need_evict && (count_ff == '0);
      // Lowest invalid slot once the least recent entry is dropped
      if (need_evict && (!free_ff || (lru_idx_ff < free_idx_ff))) begin
         free_sel = lru_idx_ff;
      end else begin
         free_sel = free_idx_ff;
      end
      sweep_go = found_ff || (is_put && !self_evict);
   end

   // Value memory access happens only in the decide cycle
   assign val_wr_en   = (state_ff == ST_DECIDE) && is_put && (found_ff || !self_evict);
   assign val_wr_addr = found_ff ? found_idx_ff : free_sel;
   assign val_rd_en   = (state_ff == ST_DECIDE) && !is_put && found_ff;

   // Tag memory: read one row a cycle, write back the previous row in the sweep
   assign tag_rd_en = ((state_ff == ST_SCAN) || (state_ff == ST_SWEEP)) && issue_live;
   assign tag_wr_en = (state_ff == ST_SWEEP) && row_live;

   always_comb begin
      if (row_idx == target_idx_ff) begin
         tag_wr_data = {(ins_ff ? key_ff : row_key), lkv_pkg::RANK_W'(0)};
      end else if (row_valid && (lkv_pkg::CNT_W'(row_rank) < thr_ff)) begin
         tag_wr_data = {row_key, row_rank + lkv_pkg::RANK_W'(1)};
      end else begin
         tag_wr_data = {row_key, row_rank};
      end
   end

   lkv_ram #(
      .WIDTH (lkv_pkg::TAG_W),
      .DEPTH (lkv_pkg::ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (row_idx),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (cnt_ff[lkv_pkg::IDX_W-1:0]),
      .rd_data (tag_rd_data)
   );

   lkv_ram #(
      .WIDTH (lkv_pkg::DATA_W),
      .DEPTH (lkv_pkg::ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (value_ff),
      .rd_en   (val_rd_en),
      .rd_addr (found_idx_ff),
      .rd_data (val_rd_data)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
         lru_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff  <= lkv_pkg::func_type'(req_func);
                  key_ff   <= lkv_pkg::key_from_req(req_key);
                  value_ff <= req_value;
                  cnt_ff   <= '0;
                  found_ff <= 1'b0;
                  lru_ff   <= 1'b0;
                  free_ff  <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + lkv_pkg::CNT_W'(1);
               if (row_live) begin
                  // First valid match
                  if (row_valid && (row_key == key_ff) && !found_ff) begin
                     found_ff      <= 1'b1;
                     found_idx_ff  <= row_idx;
                     found_rank_ff <= row_rank;
                  end
                  // Oldest valid entry
                  if (row_valid && (!lru_ff || (row_rank > lru_rank_ff))) begin
                     lru_ff      <= 1'b1;
                     lru_idx_ff  <= row_idx;
                     lru_rank_ff <= row_rank;
                     lru_key_ff  <= row_key;
                  end
                  // Lowest free slot
                  if (!row_valid && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= row_idx;
                  end
               end
               if (!issue_live) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               cnt_ff            <= '0;
               res_ff.hit        <= found_ff;
               res_ff.read_data  <= (is_put || found_ff) ? '0 : lkv_pkg::READ_MISS;
               res_ff.evicted    <= 1'b0;
               res_ff.evicted_key <= '0;
               load_value_ff     <= !is_put && found_ff;
               ins_ff            <= 1'b0;
               if (found_ff) begin
                  target_idx_ff <= found_idx_ff;
                  thr_ff        <= lkv_pkg::CNT_W'(found_rank_ff);
               end else if (is_put) begin
                  if (self_evict) begin
                     // Nothing held: the new key leaves at once
                     res_ff.evicted     <= 1'b1;
                     res_ff.evicted_key <= lkv_pkg::key_low(key_ff);
                  end else begin
                     if (need_evict) begin
                        res_ff.evicted     <= 1'b1;
                        res_ff.evicted_key <= lkv_pkg::key_low(lru_key_ff);
                        valid_ff[lru_idx_ff] <= 1'b0;
                     end else begin
                        count_ff <= count_ff + lkv_pkg::CNT_W'(1);
                     end
                     valid_ff[free_sel] <= 1'b1;
                     target_idx_ff      <= free_sel;
                     thr_ff             <= lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
                     ins_ff             <= 1'b1;
                  end
               end
               state_ff <= sweep_go ? ST_SWEEP : ST_RESP;
            end
            ST_SWEEP: begin
               cnt_ff <= cnt_ff + lkv_pkg::CNT_W'(1);
               if (!issue_live) begin
                  if (load_value_ff) begin
                     res_ff.read_data <= val_rd_data;
                  end
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (res_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP);
   assign res       = res_ff;

   // Fill count tracks the valid bits
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == lkv_pkg::CNT_W'($countones(valid_ff)))
      else $error("fill count differs from number of valid entries");

   // A hit always points at a live entry
   a_hit_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && found_ff |-> valid_ff[found_idx_ff])
      else $error("hit slot is not valid");

   // An insert never lands on a live entry other than the one being evicted
   a_insert_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && is_put && !found_ff && !self_evict |->
         (!valid_ff[free_sel] || (need_evict && (free_sel == lru_idx_ff))))
      else $error("insert slot already occupied");

   // An eviction from a non-empty store has found a victim
   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && is_put && !found_ff && need_evict && (count_ff != '0)
         |-> lru_ff)
      else $error("eviction without a least recent entry");

endmodule

// File: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
// Each request takes one pass over the tag memory, one entry a cycle through its single
// read port, to find the key, the least recent entry and the lowest free slot; a hit or an
// insert then takes a second pass over the same port to rewrite the recency ranks. A get
// that misses, or a put that evicts its own key, skips the second pass. One request is
// worked on at a time; the next is accepted while a finished result still waits in the
// output register. Valid bits live in flip-flops cleared by reset, so the block is ready
// right after reset with no clearing pass. The entry limit must be written through the
// register port only while the block is idle; the block itself does not enforce it. A
// limit above the number of slots acts as the number of slots.
module lru_key_value_cache (
   input  logic                                clock,
   input  logic                                reset,
   // Request beats
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] lookup_key, [63:32] block_value
   input  logic [lkv_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] func
   input  logic                                req_tuser,
   // Result beats
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] hit, [32:1] read_data, [33] evicted, [65:34] evicted_key, rest zero
   output logic [lkv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [lkv_pkg::LIMIT_W-1:0] entry_limit;
   logic                        res_valid;
   logic                        res_ready;
   lkv_pkg::result_type         res;
   logic                        rsp_valid_ff;
   lkv_pkg::result_type         rsp_data_ff;

   lkv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entry_limit (entry_limit)
   );

   lkv_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .entry_limit (entry_limit),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (req_tuser),
      .req_key     (req_tdata[lkv_pkg::DATA_W-1:0]),
      .req_value   (req_tdata[lkv_pkg::REQ_TDATA_W-1:lkv_pkg::DATA_W]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // Output register: take a new result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lkv_pkg::RSP_TDATA_W'(rsp_data_ff);

endmodule

// File: bench/lru_key_value_cache_tb.sv
// Self-checking bench for the LRU key-value cache: random and directed requests against a predictor.
module lru_key_value_cache_tb;
   import lkv_pkg::*;

   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 48;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Shadow copy of the cache that predicts every result beat
   class lru_cache_scoreboard;
      bit [LIMIT_W-1:0]     limit;
      bit                   slot_valid [ENTRIES];
      bit [KEY_WIDTH-1:0]   slot_key   [ENTRIES];
      bit [DATA_W-1:0]      slot_value [ENTRIES];
      int unsigned          slot_rank  [ENTRIES];
      int                   occupied;
      result_type           expected_q [$];
      int                   errors;

      function new();
         limit    = LIMIT_RESET;
         occupied = 0;
         errors   = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Age every entry that was more recent than slot s, then make s the newest
      function void make_recent(input int s);
         int unsigned old_rank;
         old_rank = slot_rank[s];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] < old_rank)
               slot_rank[i]++;
         slot_rank[s] = 0;
      endfunction

      // Apply one accepted request to the shadow store and queue its result
      function void note_request(input func_type f, input logic [DATA_W-1:0] raw_key,
                                 input logic [DATA_W-1:0] value);
         logic signed [63:0]   wide;
         logic [63:0]          key_ext;
         logic [KEY_WIDTH-1:0] k;
         result_type           r;
         int                   slot;
         int                   lru;
         int                   eff_limit;
         wide = signed'(raw_key);
         k    = wide[KEY_WIDTH-1:0];
         r    = '0;
         slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && slot_valid[i] && slot_key[i] == k)
               slot = i;
         if (f == FUNC_GET) begin
            if (slot >= 0) begin
               r.hit       = 1'b1;
               r.read_data = slot_value[slot];
               make_recent(slot);
            end else begin
               r.read_data = '1;
            end
         end else if (slot >= 0) begin
            r.hit            = 1'b1;
            slot_value[slot] = value;
            make_recent(slot);
         end else begin
            eff_limit = (limit > ENTRIES) ? ENTRIES : int'(limit);
            if (occupied + 1 > eff_limit) begin
               r.evicted = 1'b1;
               // Empty store with a zero limit: the new key bounces straight out
               if (occupied == 0) begin
                  key_ext       = 64'(k);
                  r.evicted_key = key_ext[DATA_W-1:0];
                  expected_q.push_back(r);
                  return;
               end
               lru = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_valid[i] && (lru < 0 || slot_rank[i] > slot_rank[lru]))
                     lru = i;
               key_ext         = 64'(slot_key[lru]);
               r.evicted_key   = key_ext[DATA_W-1:0];
               slot_valid[lru] = 1'b0;
               occupied--;
            end
            // Insert into the lowest free slot as the newest entry
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !slot_valid[i])
                  slot = i;
            if (slot >= 0) begin
               for (int j = 0; j < ENTRIES; j++)
                  if (slot_valid[j])
                     slot_rank[j]++;
               slot_valid[slot] = 1'b1;
               slot_key[slot]   = k;
               slot_value[slot] = value;
               slot_rank[slot]  = 0;
               occupied++;
            end
         end
         expected_q.push_back(r);
      endfunction

      // Compare one result beat with the oldest prediction
      task check_result(input logic [RSP_TDATA_W-1:0] beat);
         result_type got;
         result_type want;
         got = result_type'(beat[RESULT_W-1:0]);
         if (expected_q.size() == 0) begin
            report("result beat with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("hit %0b, predicted %0b", got.hit, want.hit));
         if (got.read_data !== want.read_data)
            report($sformatf("read_data %h, predicted %h", got.read_data, want.read_data));
         if (got.evicted !== want.evicted)
            report($sformatf("evicted %0b, predicted %0b", got.evicted, want.evicted));
         if (got.evicted_key !== want.evicted_key)
            report($sformatf("evicted_key %h, predicted %h",
                             got.evicted_key, want.evicted_key));
         if (beat[RSP_TDATA_W-1:RESULT_W] !== '0)
            report($sformatf("padding bits %h not zero", beat[RSP_TDATA_W-1:RESULT_W]));
      endtask
   endclass

   lru_cache_scoreboard sb = new();

   int send_idle;
   int recv_idle;
   bit want_hold;

   lru_key_value_cache u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run in case the block hangs
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Result side: check each beat, stall at random or for a long hold
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            sb.check_result(rsp_tdata);
         if (want_hold) begin
            hold_left = HOLD_CYCLES;
            want_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Offer one request beat after a random gap; return at the edge that takes it
   task send_item(input func_type f, input logic [DATA_W-1:0] key,
                  input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {value, key};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(f, key, value);
   endtask

   // Drop the request side and wait for every outstanding result
   task drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Let the block go quiet before touching the register
   task settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup beat, then access beat
   task write_limit(input bit [LIMIT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({REG_ENTRY_LIMIT, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.limit = value;
   endtask

   initial begin
      logic [DATA_W-1:0] pool [32];
      logic [DATA_W-1:0] extremes [4];
      bit [LIMIT_W-1:0]  phase_limit [RANDOM_PHASES];
      logic [DATA_W-1:0] key;
      func_type          f;
      int                pool_n;

      extremes    = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
      phase_limit = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd3, 5'd0, 5'd8, 5'd16};
      send_idle   = 10;
      recv_idle   = 53;
      want_hold   = 1'b0;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero limit on an empty store: the put evicts its own key
      write_limit(5'd0);
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      settle();

      // Limit above the slot count; extreme keys and values, hits and misses
      write_limit(5'd31);
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h1234_5678);
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA);
      send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
      settle();

      // Limit lowered below the count: each new key evicts one entry
      write_limit(5'd2);
      send_item(FUNC_PUT, 32'hA5A5_5A5A, 32'hAAAA_5555);
      send_item(FUNC_PUT, 32'h0F0F_F0F0, 32'hF0F0_0F0F);
      send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
      settle();

      // Random phases over a small key pool so hits and evictions both happen
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 3) begin
            send_idle = 10;
            recv_idle = 53;
         end else if (p < 6) begin
            send_idle = 53;
            recv_idle = 10;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_limit(phase_limit[p]);
         pool_n = ((phase_limit[p] > ENTRIES) ? ENTRIES : int'(phase_limit[p])) + 4;
         for (int i = 0; i < pool_n; i++)
            pool[i] = $urandom();
         pool[0] = extremes[p % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold the result side off so the block backs up into the request side
            if (p == 2 && n == 4)
               want_hold = 1'b1;
            // Pause requests until every result is back
            if (p == 6 && n == PHASE_ITEMS / 2)
               drain();
            f = func_type'($urandom_range(1));
            if ($urandom_range(99) < 85)
               key = pool[$urandom_range(pool_n - 1)];
            else
               key = $urandom();
            send_item(f, key, $urandom());
         end
         settle();
      end

      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: lru_key_value_cache.f
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_csr.sv
rtl/lkv_engine.sv
rtl/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
